[src/pcfpc_pkg.sv]
// ----------------------------------------------------------------------------
// pcfpc_pkg
// Shared types and fixed field widths of the per-CPU free-pointer cache.
// ----------------------------------------------------------------------------
package pcfpc_pkg;

   localparam int PTR_W     = 48;
   localparam int CPU_IDX_W = 8;
   localparam int CLASS_W   = 8;
   localparam int STATUS_W  = 3;

   // request opcodes
   typedef enum logic {
      CMD_POP  = 1'b0,
      CMD_PUSH = 1'b1
   } command_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_EMPTY     = 3'd1,
      STAT_FULL      = 3'd2,
      STAT_BAD_CLASS = 3'd3,
      STAT_BAD_CPU   = 3'd4,
      STAT_DISABLED  = 3'd5
   } status_type;

   // controller states
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_DECIDE,
      S_SLOT,
      S_FINISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic depth_rd;
      logic set_refusal;
      logic set_outcome;
      logic load_ptr;
      logic rsp_load;
   } ctrl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clear_last;
      logic refused;
      logic pop_hit;
      logic out_busy;
   } dp_stat_type;

endpackage

[src/pcfpc_req_if.sv]
// ----------------------------------------------------------------------------
// pcfpc_req_if
// Request channel: valid/ready handshake with pop/push payload.
// ----------------------------------------------------------------------------
interface pcfpc_req_if;
   logic                              valid;
   logic                              ready;
   logic                              command;
   logic signed [pcfpc_pkg::CPU_IDX_W-1:0] cpu_index;
   logic [pcfpc_pkg::CLASS_W-1:0]     size_class;
   logic [pcfpc_pkg::PTR_W-1:0]       pointer_in;

   modport source (output valid, command, cpu_index, size_class, pointer_in,
                   input ready);
   modport sink (input valid, command, cpu_index, size_class, pointer_in,
                 output ready);
endinterface

[src/pcfpc_rsp_if.sv]
// ----------------------------------------------------------------------------
// pcfpc_rsp_if
// Result channel: valid/ready handshake with outcome payload.
// ----------------------------------------------------------------------------
interface pcfpc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           accepted;
   logic [pcfpc_pkg::PTR_W-1:0]    pointer_out;
   logic [pcfpc_pkg::STATUS_W-1:0] status;

   modport source (output valid, accepted, pointer_out, status, input ready);
   modport sink (input valid, accepted, pointer_out, status, output ready);
endinterface

[src/pcfpc_ram.sv]
// ----------------------------------------------------------------------------
// pcfpc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcfpc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pcfpc_ctrl.sv]
// ----------------------------------------------------------------------------
// pcfpc_ctrl
// Sequencer: clearing pass, request capture, depth lookup, stack update,
// slot read and result handoff.
// ----------------------------------------------------------------------------
module pcfpc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  pcfpc_pkg::dp_stat_type  stat,
   output pcfpc_pkg::ctrl_cmd_type cmd
);

   pcfpc_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pcfpc_pkg::S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcfpc_pkg::S_CLEAR: begin
            if (stat.clear_last) state_in = pcfpc_pkg::S_IDLE;
         end
         pcfpc_pkg::S_IDLE: begin
            if (req_valid) state_in = pcfpc_pkg::S_LOOKUP;
         end
         pcfpc_pkg::S_LOOKUP: begin
            state_in = stat.refused ? pcfpc_pkg::S_FINISH : pcfpc_pkg::S_DECIDE;
         end
         pcfpc_pkg::S_DECIDE: begin
            state_in = stat.pop_hit ? pcfpc_pkg::S_SLOT : pcfpc_pkg::S_FINISH;
         end
         pcfpc_pkg::S_SLOT: begin
            state_in = pcfpc_pkg::S_FINISH;
         end
         pcfpc_pkg::S_FINISH: begin
            if (!stat.out_busy) state_in = pcfpc_pkg::S_IDLE;
         end
         default: state_in = pcfpc_pkg::S_CLEAR;
      endcase
   end

   // command decode
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pcfpc_pkg::S_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         pcfpc_pkg::S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         pcfpc_pkg::S_LOOKUP: begin
            cmd.set_refusal = stat.refused;
            cmd.depth_rd    = !stat.refused;
         end
         pcfpc_pkg::S_DECIDE: begin
            cmd.set_outcome = 1'b1;
         end
         pcfpc_pkg::S_SLOT: begin
            cmd.load_ptr = 1'b1;
         end
         pcfpc_pkg::S_FINISH: begin
            cmd.rsp_load = !stat.out_busy;
         end
         default: cmd = '0;
      endcase
   end

endmodule

[src/pcfpc_dpath.sv]
// ----------------------------------------------------------------------------
// pcfpc_dpath
// Datapath: request registers, range checks, depth and slot memories,
// result staging and the output register.
// ----------------------------------------------------------------------------
module pcfpc_dpath #(
   parameter int NUM_CPUS       = 8,
   parameter int NUM_CLASSES    = 16,
   parameter int STACK_CAPACITY = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic                                   csr_wr_data,
   // request payload
   input  logic                                   req_command,
   input  logic signed [pcfpc_pkg::CPU_IDX_W-1:0] req_cpu_index,
   input  logic [pcfpc_pkg::CLASS_W-1:0]          req_size_class,
   input  logic [pcfpc_pkg::PTR_W-1:0]            req_pointer_in,
   // result channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_accepted,
   output logic [pcfpc_pkg::PTR_W-1:0]            rsp_pointer_out,
   output logic [pcfpc_pkg::STATUS_W-1:0]         rsp_status,
   // controller link
   input  pcfpc_pkg::ctrl_cmd_type                cmd,
   output pcfpc_pkg::dp_stat_type                 stat
);

   localparam int NUM_STACKS = NUM_CPUS * NUM_CLASSES;
   localparam int NUM_SLOTS  = NUM_STACKS * STACK_CAPACITY;
   localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int STK_W      = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam int SLOT_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int DEP_W      = $clog2(STACK_CAPACITY + 1);
   localparam int CHK_W      = pcfpc_pkg::CLASS_W + 1;

   // configuration
   logic cache_enable_ff;

   // captured request
   pcfpc_pkg::command_type                 cmd_ff;
   logic signed [pcfpc_pkg::CPU_IDX_W-1:0] cpu_ff;
   logic [pcfpc_pkg::CLASS_W-1:0]          cls_ff;
   logic [pcfpc_pkg::PTR_W-1:0]            ptr_ff;

   // clearing pass
   logic [STK_W-1:0] clr_ff;

   // staged result
   logic                         res_acc_ff;
   logic [pcfpc_pkg::PTR_W-1:0]  res_ptr_ff;
   pcfpc_pkg::status_type        res_status_ff;

   // output register
   logic                         rsp_valid_ff;
   logic                         rsp_acc_ff;
   logic [pcfpc_pkg::PTR_W-1:0]  rsp_ptr_ff;
   pcfpc_pkg::status_type        rsp_status_ff;

   // lookup and update signals
   logic                         bad_class;
   logic                         bad_cpu;
   pcfpc_pkg::status_type        pre_status;
   logic [STK_W-1:0]             stack_idx;
   logic [DEP_W-1:0]             depth;
   logic                         is_pop;
   logic                         empty;
   logic                         full;
   logic                         pop_hit;
   logic                         push_ok;
   logic [DEP_W-1:0]             slot_off;
   logic [SLOT_AW-1:0]           slot_addr;
   logic                         dep_wr_en;
   logic [STK_W-1:0]             dep_wr_addr;
   logic [DEP_W-1:0]             dep_wr_data;
   logic                         slot_wr_en;
   logic                         slot_rd_en;
   logic [pcfpc_pkg::PTR_W-1:0]  slot_rd_data;

   // hold the enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         cache_enable_ff <= 1'b0;
      end else if (csr_wr_en) begin
         cache_enable_ff <= csr_wr_data;
      end
   end

   // capture the request on transfer
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff <= pcfpc_pkg::command_type'(req_command);
         cpu_ff <= req_cpu_index;
         cls_ff <= req_size_class;
         ptr_ff <= req_pointer_in;
      end
   end

   // range checks in priority order
   assign bad_class = CHK_W'(cls_ff) >= CHK_W'(NUM_CLASSES);
   assign bad_cpu   = cpu_ff[pcfpc_pkg::CPU_IDX_W-1]
                      || (CHK_W'($unsigned(cpu_ff)) >= CHK_W'(NUM_CPUS));

   always_comb begin
      if (!cache_enable_ff) begin
         pre_status = pcfpc_pkg::STAT_DISABLED;
      end else if (bad_class) begin
         pre_status = pcfpc_pkg::STAT_BAD_CLASS;
      end else if (bad_cpu) begin
         pre_status = pcfpc_pkg::STAT_BAD_CPU;
      end else begin
         pre_status = pcfpc_pkg::STAT_OK;
      end
   end

   // stack number and slot address
   assign stack_idx = STK_W'(32'(cpu_ff[CPU_W-1:0]) * 32'(NUM_CLASSES)
                             + 32'(cls_ff[CLS_W-1:0]));
   assign is_pop    = (cmd_ff == pcfpc_pkg::CMD_POP);
   assign empty     = (depth == '0);
   assign full      = (depth >= DEP_W'(STACK_CAPACITY));
   assign pop_hit   = is_pop && !empty;
   assign push_ok   = !is_pop && !full;
   assign slot_off  = is_pop ? (depth - DEP_W'(1)) : depth;
   assign slot_addr = SLOT_AW'(32'(stack_idx) * 32'(STACK_CAPACITY) + 32'(slot_off));

   // advance the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !stat.clear_last) begin
         clr_ff <= clr_ff + STK_W'(1);
      end
   end

   // depth memory write port: clearing pass or stack update
   always_comb begin
      if (cmd.clear_step) begin
         dep_wr_en   = 1'b1;
         dep_wr_addr = clr_ff;
         dep_wr_data = '0;
      end else begin
         dep_wr_en   = cmd.set_outcome && (pop_hit || push_ok);
         dep_wr_addr = stack_idx;
         dep_wr_data = is_pop ? (depth - DEP_W'(1)) : (depth + DEP_W'(1));
      end
   end

   assign slot_wr_en = cmd.set_outcome && push_ok;
   assign slot_rd_en = cmd.set_outcome && pop_hit;

   pcfpc_ram #(
      .WIDTH (DEP_W),
      .DEPTH (NUM_STACKS)
   ) u_depth_ram (
      .clock   (clock),
      .wr_en   (dep_wr_en),
      .wr_addr (dep_wr_addr),
      .wr_data (dep_wr_data),
      .rd_en   (cmd.depth_rd),
      .rd_addr (stack_idx),
      .rd_data (depth)
   );

   pcfpc_ram #(
      .WIDTH (pcfpc_pkg::PTR_W),
      .DEPTH (NUM_SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_addr),
      .wr_data (ptr_ff),
      .rd_en   (slot_rd_en),
      .rd_addr (slot_addr),
      .rd_data (slot_rd_data)
   );

   // stage the result
   always_ff @(posedge clock) begin
      if (cmd.set_refusal) begin
         res_acc_ff    <= 1'b0;
         res_ptr_ff    <= '0;
         res_status_ff <= pre_status;
      end else if (cmd.set_outcome) begin
         res_acc_ff <= pop_hit || push_ok;
         res_ptr_ff <= '0;
         if (is_pop) begin
            res_status_ff <= empty ? pcfpc_pkg::STAT_EMPTY : pcfpc_pkg::STAT_OK;
         end else begin
            res_status_ff <= full ? pcfpc_pkg::STAT_FULL : pcfpc_pkg::STAT_OK;
         end
      end else if (cmd.load_ptr) begin
         res_ptr_ff <= slot_rd_data;
      end
   end

   // output register: load when free, drop on transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_acc_ff    <= res_acc_ff;
         rsp_ptr_ff    <= res_ptr_ff;
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_pointer_out = rsp_ptr_ff;
   assign rsp_status      = rsp_status_ff;

   // status to the controller
   assign stat.clear_last = (clr_ff == STK_W'(NUM_STACKS - 1));
   assign stat.refused    = (pre_status != pcfpc_pkg::STAT_OK);
   assign stat.pop_hit    = pop_hit;
   assign stat.out_busy   = rsp_valid_ff && !rsp_ready;

endmodule

[src/per_cpu_free_pointer_cache_unit.sv]
// ----------------------------------------------------------------------------
// per_cpu_free_pointer_cache_unit: one request at a time through the depth and slot RAMs.
// Requests: the next is taken only after the last result is loaded, as depth and slot are accessed in turn.
// Reset: clears the enable and runs a pass over all NUM_CPUS*NUM_CLASSES stacks zeroing their depths.
// ----------------------------------------------------------------------------
module per_cpu_free_pointer_cache_unit #(
   parameter int NUM_CPUS       = 8,
   parameter int NUM_CLASSES    = 16,
   parameter int STACK_CAPACITY = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_wr_data,
   pcfpc_req_if.sink     req_bus,
   pcfpc_rsp_if.source   rsp_bus
);

   pcfpc_pkg::ctrl_cmd_type cmd;
   pcfpc_pkg::dp_stat_type  stat;

   // sequencer
   pcfpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   pcfpc_dpath #(
      .NUM_CPUS       (NUM_CPUS),
      .NUM_CLASSES    (NUM_CLASSES),
      .STACK_CAPACITY (STACK_CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_command     (req_bus.command),
      .req_cpu_index   (req_bus.cpu_index),
      .req_size_class  (req_bus.size_class),
      .req_pointer_in  (req_bus.pointer_in),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_accepted    (rsp_bus.accepted),
      .rsp_pointer_out (rsp_bus.pointer_out),
      .rsp_status      (rsp_bus.status),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives pop and push requests into the per-CPU free-pointer cache, keeps a
// shadow copy of every stack depth and slot plus the enable bit, and checks
// each result transfer, field by field, in order against the shadow copy.
// Both channels are throttled at random, and the result side is held off
// for a long stretch so that the block backs up into its request port.
// ----------------------------------------------------------------------------
module testbench;
   import pcfpc_pkg::*;

   localparam int CLK_PERIOD     = 20;
   localparam int NUM_CPUS       = 8;
   localparam int NUM_CLASSES    = 16;
   localparam int STACK_CAPACITY = 16;
   localparam int NUM_STACKS     = NUM_CPUS * NUM_CLASSES;
   localparam int HOLD_CYCLES    = 300;
   localparam int STALL_LIMIT    = 3000;
   localparam int TAIL_CYCLES    = 20;
   localparam int MAX_REPORTS    = 10;
   localparam logic [PTR_W-1:0] PTR_ONES = '1;

   typedef struct {
      logic             accepted;
      logic [PTR_W-1:0] pointer_out;
      status_type       status;
   } outcome_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_wr_data;

   pcfpc_req_if req_bus ();
   pcfpc_rsp_if rsp_bus ();

   per_cpu_free_pointer_cache_unit #(
      .NUM_CPUS       (NUM_CPUS),
      .NUM_CLASSES    (NUM_CLASSES),
      .STACK_CAPACITY (STACK_CAPACITY)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus)
   );

   // shadow copy of the cache state
   bit               shadow_enable;
   int               shadow_depth [NUM_STACKS];
   logic [PTR_W-1:0] shadow_slot  [NUM_STACKS][STACK_CAPACITY];

   outcome_type pending_outcomes [$];
   int          fail_count;
   int          tx_idle_pct;
   int          rx_idle_pct;
   bit          rx_hold_req;
   bit          rx_hold_ack;
   int          rx_hold_left;
   int          quiet_cycles;

   // free-running clock
   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   // compute the result of one request and update the shadow stacks
   function automatic outcome_type cache_outcome(command_type cmd,
                                                 logic signed [CPU_IDX_W-1:0] cpu,
                                                 logic [CLASS_W-1:0] cls,
                                                 logic [PTR_W-1:0] addr);
      outcome_type res;
      int          stack_id;
      int          depth;
      res.accepted    = 1'b0;
      res.pointer_out = '0;
      res.status      = STAT_OK;
      if (!shadow_enable) begin
         res.status = STAT_DISABLED;
      end else if (cls >= NUM_CLASSES) begin
         res.status = STAT_BAD_CLASS;
      end else if (cpu < 0 || cpu >= NUM_CPUS) begin
         res.status = STAT_BAD_CPU;
      end else begin
         stack_id = int'(cpu) * NUM_CLASSES + int'(cls);
         depth    = shadow_depth[stack_id];
         if (cmd == CMD_POP) begin
            if (depth == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               depth                  = depth - 1;
               shadow_depth[stack_id] = depth;
               res.accepted           = 1'b1;
               res.pointer_out        = shadow_slot[stack_id][depth];
            end
         end else if (depth >= STACK_CAPACITY) begin
            res.status = STAT_FULL;
         end else begin
            shadow_slot[stack_id][depth] = addr;
            shadow_depth[stack_id]       = depth + 1;
            res.accepted                 = 1'b1;
         end
      end
      return res;
   endfunction

   // track config writes and request transfers, check result transfers
   always @(posedge clock) begin : scoreboard
      outcome_type want;
      if (!reset) begin
         if (csr_wr_en)
            shadow_enable = csr_wr_data;
         if (req_bus.valid && req_bus.ready)
            pending_outcomes.push_back(cache_outcome(command_type'(req_bus.command),
                                                     req_bus.cpu_index,
                                                     req_bus.size_class,
                                                     req_bus.pointer_in));
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_outcomes.size() == 0) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: result with nothing pending: acc=%0b ptr=%h st=%0d",
                           $realtime, rsp_bus.accepted, rsp_bus.pointer_out,
                           rsp_bus.status);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_bus.accepted !== want.accepted ||
                   rsp_bus.pointer_out !== want.pointer_out ||
                   rsp_bus.status !== want.status) begin
                  fail_count++;
                  if (fail_count <= MAX_REPORTS)
                     $display("%0t: mismatch: expected acc=%0b ptr=%h st=%0d, got acc=%0b ptr=%h st=%0d",
                              $realtime, want.accepted, want.pointer_out, want.status,
                              rsp_bus.accepted, rsp_bus.pointer_out, rsp_bus.status);
               end
            end
         end
      end
   end

   // throttle the result side; a hold-off request forces a long stall
   always @(posedge clock) begin
      if (rx_hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         rx_hold_left  <= rx_hold_left - 1;
      end else if (rx_hold_req != rx_hold_ack) begin
         rx_hold_ack   <= rx_hold_req;
         rx_hold_left  <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // end the run when no transfer happens for too long
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
         $display("** per_cpu_free_pointer_cache_unit: FAILED **");
         $finish;
      end
   end

   function automatic logic [PTR_W-1:0] random_address();
      return PTR_W'({$urandom(), $urandom()});
   endfunction

   // offer one request and hold it until the transfer; valid stays high after
   task automatic send_request(command_type cmd, logic signed [CPU_IDX_W-1:0] cpu,
                               logic [CLASS_W-1:0] cls, logic [PTR_W-1:0] addr);
      if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.command    <= cmd;
      req_bus.cpu_index  <= cpu;
      req_bus.size_class <= cls;
      req_bus.pointer_in <= addr;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // drop valid and wait until every pending result has been checked
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_outcomes.size() != 0);
   endtask

   // write the enable register while the block is idle
   task automatic write_enable(bit value);
      wait_drained();
      while (!req_bus.ready) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // everything is refused while the cache is disabled
   task automatic test_disabled_refusal();
      send_request(CMD_POP, 8'sd0, 8'd0, '0);
      send_request(CMD_PUSH, -8'sd1, 8'd255, PTR_ONES);
      send_request(CMD_PUSH, 8'sd127, 8'd16, random_address());
   endtask

   // class check, including its priority over the cpu check
   task automatic test_class_check();
      send_request(CMD_PUSH, 8'sd0, 8'(NUM_CLASSES), random_address());
      send_request(CMD_POP, -8'sd1, 8'd255, '0);
      send_request(CMD_POP, 8'sd3, 8'd128, PTR_ONES);
   endtask

   // negative and out-of-range cpu numbers
   task automatic test_cpu_check();
      send_request(CMD_PUSH, -8'sd1, 8'd0, random_address());
      send_request(CMD_POP, 8'(NUM_CPUS), 8'(NUM_CLASSES - 1), '0);
      send_request(CMD_PUSH, 8'sd127, 8'd3, PTR_ONES);
   endtask

   // empty miss, extreme addresses and last-in-first-out order on the last stack
   task automatic test_stack_order();
      send_request(CMD_POP, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), PTR_ONES);
      send_request(CMD_PUSH, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), PTR_ONES);
      send_request(CMD_PUSH, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), '0);
      send_request(CMD_PUSH, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), 48'hAAAA_AAAA_AAAA);
      send_request(CMD_PUSH, 8'sd0, 8'd0, 48'h5555_5555_5555);
      repeat (3) send_request(CMD_POP, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), '0);
      send_request(CMD_POP, 8'sd0, 8'd0, PTR_ONES);
      send_request(CMD_POP, 8'(NUM_CPUS - 1), 8'(NUM_CLASSES - 1), '0);
   endtask

   // stall the result side while requests keep coming, then let it drain
   task automatic test_backpressure();
      int saved_tx;
      saved_tx    = tx_idle_pct;
      tx_idle_pct = 0;
      rx_hold_req = ~rx_hold_req;
      repeat (12) send_request(CMD_PUSH, 8'sd1, 8'd1, random_address());
      repeat (12) send_request(CMD_POP, 8'sd1, 8'd1, '0);
      wait_drained();
      tx_idle_pct = saved_tx;
   endtask

   // random sequences aimed at a few hot stacks, plus refused noise
   task automatic random_traffic(int count);
      int                          sent;
      int                          kind;
      int                          burst;
      logic signed [CPU_IDX_W-1:0] cpu;
      logic [CLASS_W-1:0]          cls;
      sent = 0;
      while (sent < count) begin
         kind = $urandom_range(99);
         if ($urandom_range(99) < 60) begin
            cpu = 8'($urandom_range(0, 1));
            cls = 8'($urandom_range(0, 1));
         end else begin
            cpu = 8'($urandom_range(0, NUM_CPUS - 1));
            cls = 8'($urandom_range(0, NUM_CLASSES - 1));
         end
         if (kind < 10) begin
            // mostly refused noise: any class, and a cpu from -1 up to 127
            cpu = 8'($urandom_range(0, 128) - 1);
            cls = 8'($urandom_range(0, 255));
            send_request(command_type'($urandom_range(1)), cpu, cls, random_address());
            sent++;
         end else if (kind < 20) begin
            // fill past capacity to reach the overflow
            repeat (STACK_CAPACITY + 2)
               send_request(CMD_PUSH, cpu, cls, random_address());
            sent += STACK_CAPACITY + 2;
         end else if (kind < 28) begin
            // drain past empty
            repeat (STACK_CAPACITY + 2) send_request(CMD_POP, cpu, cls, random_address());
            sent += STACK_CAPACITY + 2;
         end else begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
               if ($urandom_range(99) < 55)
                  send_request(CMD_PUSH, cpu, cls, random_address());
               else
                  send_request(CMD_POP, cpu, cls, random_address());
            end
            sent += burst;
         end
      end
   endtask

   // three idling profiles with a disabled stretch in between
   task automatic test_random_traffic();
      random_traffic(600);
      write_enable(1'b0);
      random_traffic(60);
      write_enable(1'b1);
      tx_idle_pct = 49;
      rx_idle_pct = 8;
      random_traffic(500);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      random_traffic(450);
   endtask

   initial begin
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_wr_data        = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_POP;
      req_bus.cpu_index  = '0;
      req_bus.size_class = '0;
      req_bus.pointer_in = '0;
      rsp_bus.ready      = 1'b0;
      fail_count         = 0;
      quiet_cycles       = 0;
      rx_hold_req        = 1'b0;
      rx_hold_ack        = 1'b0;
      rx_hold_left       = 0;
      tx_idle_pct        = 8;
      rx_idle_pct        = 49;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_disabled_refusal();
      write_enable(1'b1);
      test_class_check();
      test_cpu_check();
      test_stack_order();
      test_backpressure();
      test_random_traffic();

      // let the last results land, then settle
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_outcomes.size() == 0)
         $display("** per_cpu_free_pointer_cache_unit: PASSED **");
      else
         $display("** per_cpu_free_pointer_cache_unit: FAILED **");
      $finish;
   end

endmodule
